/* hdl/mmc3o_pkg.sv */
// Types and constants shared by the outer-bank mapper modules.
`timescale 1ns / 1ps

package mmc3o_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE_HI = 2'd0,
    REQ_WRITE_LO = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_PRG_COUNT   = 2'd0,
    CFG_CHR_COUNT   = 2'd1,
    CFG_FOUR_SCREEN = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_HOLD
  } state_e;

  localparam logic [15:0] DECODE_MASK  = 16'hE001;
  localparam logic [15:0] REG_BANK_SEL = 16'h8000;
  localparam logic [15:0] REG_BANK_DAT = 16'h8001;
  localparam logic [15:0] REG_MIRROR   = 16'hA000;
  localparam logic [15:0] REG_IRQ_LAT  = 16'hC000;
  localparam logic [15:0] REG_IRQ_RLD  = 16'hC001;
  localparam logic [15:0] REG_IRQ_DIS  = 16'hE000;
  localparam logic [15:0] REG_IRQ_EN   = 16'hE001;
  localparam logic [15:0] OUTER_BASE   = 16'h4120;

  localparam logic [1:0] MIRROR_FOUR = 2'd2;

  localparam int unsigned NUM_LANES  = 9;
  localparam int unsigned PRG_LANE   = 8;
  localparam int unsigned CALC_STEPS = 4;

  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic out_load;
  } ctrl_cmd_t;

endpackage

/* hdl/mmc3o_if.sv */
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps

interface mmc3o_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] address;
  logic [7:0]  data;
  logic        rendering_enabled;

  modport source (output valid, req_type, address, data, rendering_enabled, input ready);
  modport sink   (input valid, req_type, address, data, rendering_enabled, output ready);
endinterface

interface mmc3o_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] prg_bank;
  logic [7:0] chr_page0;
  logic [7:0] chr_page1;
  logic [7:0] chr_page2;
  logic [7:0] chr_page3;
  logic [7:0] chr_page4;
  logic [7:0] chr_page5;
  logic [7:0] chr_page6;
  logic [7:0] chr_page7;
  logic [1:0] mirror_mode;
  logic       irq_fire;
  logic       irq_clear;

  modport source (output valid, prg_bank, chr_page0, chr_page1, chr_page2, chr_page3,
                  chr_page4, chr_page5, chr_page6, chr_page7, mirror_mode, irq_fire,
                  irq_clear, input ready);
  modport sink   (input valid, prg_bank, chr_page0, chr_page1, chr_page2, chr_page3,
                  chr_page4, chr_page5, chr_page6, chr_page7, mirror_mode, irq_fire,
                  irq_clear, output ready);
endinterface

interface mmc3o_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/mmc3_style_mapper_with_outer_prg_bank.sv */
// Top level of the MMC3-style mapper with an outer 32KB PRG bank register.
// An item (CPU write or scanline tick) updates the mapper registers at the
// edge that accepts it. Then ST_LOAD loads nine remainder lanes, ST_CALC
// steps reduce the eight CHR pages and the PRG bank modulo the configured
// bank counts at two bits per cycle, and ST_HOLD registers the result. The
// input is ready again in the cycle after the result is registered. A new
// item is taken while the previous result still waits in the output
// register; that item then holds in ST_HOLD until the output is free.
// Configuration writes are taken in any cycle and belong where no item is in
// flight.
`timescale 1ns / 1ps

module mmc3_style_mapper_with_outer_prg_bank (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmc3o_in_if.sink    in_chan_i,
  mmc3o_cfg_if.sink   cfg_chan_i,
  mmc3o_out_if.source out_chan_o
);

  mmc3o_pkg::ctrl_cmd_t cmd;

  mmc3o_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan_i.valid),
    .in_ready_o  (in_chan_i.ready),
    .out_valid_o (out_chan_o.valid),
    .out_ready_i (out_chan_o.ready),
    .cmd_o       (cmd)
  );

  mmc3o_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .in_chan  (in_chan_i),
    .cfg_chan (cfg_chan_i),
    .out_chan (out_chan_o)
  );

endmodule

/* hdl/mmc3o_mod_lane.sv */
// Remainder lane: 8-bit dividend modulo 12-bit divisor, two bits per step.
`timescale 1ns / 1ps

module mmc3o_mod_lane (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic        step_i,
  input  logic [7:0]  dividend_i,
  input  logic [11:0] divisor_i,
  output logic [7:0]  rem_o
);

  logic [11:0] rem_q, rem_d;
  logic [7:0]  num_q, num_d;
  logic [11:0] div_q;
  logic [12:0] t0, t1;
  logic [11:0] r0;

  always_comb begin
    t0 = {rem_q, num_q[7]};
    r0 = (t0 >= {1'b0, div_q}) ? 12'(t0 - {1'b0, div_q}) : t0[11:0];
    t1 = {r0, num_q[6]};
    rem_d = (t1 >= {1'b0, div_q}) ? 12'(t1 - {1'b0, div_q}) : t1[11:0];
    num_d = {num_q[5:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= '0;
      num_q <= dividend_i;
      div_q <= divisor_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
    end
  end

  assign rem_o = rem_q[7:0];

endmodule

/* hdl/mmc3o_dp.sv */
// Datapath: mapper registers, remainder lanes and result register.
`timescale 1ns / 1ps

module mmc3o_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mmc3o_pkg::ctrl_cmd_t  cmd_i,
  mmc3o_in_if.sink              in_chan,
  mmc3o_cfg_if.sink             cfg_chan,
  mmc3o_out_if.source           out_chan
);

  logic [9:0]  prg_cnt_q;
  logic [11:0] chr_cnt_q;
  logic        four_q;

  logic        mode_q, mode_d;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  bank_q [6];
  logic [7:0]  bank_d [6];
  logic        mirror_q, mirror_d;
  logic [7:0]  latch_q, latch_d;
  logic [7:0]  count_q, count_d;
  logic        reload_q, reload_d;
  logic        enable_q, enable_d;
  logic [2:0]  outer_q, outer_d;
  logic        fire_q, fire_d;
  logic        clear_q, clear_d;

  logic [7:0]  dividend [mmc3o_pkg::NUM_LANES];
  logic [11:0] divisor  [mmc3o_pkg::NUM_LANES];
  logic [7:0]  rem      [mmc3o_pkg::NUM_LANES];
  logic [7:0]  prg32;
  logic [7:0]  data_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_cnt_q <= 10'd16;
      chr_cnt_q <= 12'd128;
      four_q    <= 1'b0;
    end else if (cfg_chan.valid) begin
      case (mmc3o_pkg::cfg_idx_e'(cfg_chan.index))
        mmc3o_pkg::CFG_PRG_COUNT:   prg_cnt_q <= cfg_chan.data[9:0];
        mmc3o_pkg::CFG_CHR_COUNT:   chr_cnt_q <= cfg_chan.data;
        mmc3o_pkg::CFG_FOUR_SCREEN: four_q    <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_chan.ready = 1'b1;
  assign data_hi = {4'b0000, in_chan.data[7:4]};

  always_comb begin
    mode_d   = mode_q;
    idx_d    = idx_q;
    bank_d   = bank_q;
    mirror_d = mirror_q;
    latch_d  = latch_q;
    count_d  = count_q;
    reload_d = reload_q;
    enable_d = enable_q;
    outer_d  = outer_q;
    fire_d   = 1'b0;
    clear_d  = 1'b0;
    case (mmc3o_pkg::req_e'(in_chan.req_type))
      mmc3o_pkg::REQ_WRITE_HI: begin
        case (in_chan.address & mmc3o_pkg::DECODE_MASK)
          mmc3o_pkg::REG_BANK_SEL: begin
            mode_d = in_chan.data[7];
            idx_d  = in_chan.data[2:0];
          end
          mmc3o_pkg::REG_BANK_DAT: begin
            if (idx_q < 3'd6) bank_d[idx_q] = in_chan.data;
          end
          mmc3o_pkg::REG_MIRROR:  mirror_d = in_chan.data[0];
          mmc3o_pkg::REG_IRQ_LAT: latch_d = in_chan.data;
          mmc3o_pkg::REG_IRQ_RLD: begin
            count_d  = '0;
            reload_d = 1'b1;
          end
          mmc3o_pkg::REG_IRQ_DIS: begin
            enable_d = 1'b0;
            clear_d  = 1'b1;
          end
          mmc3o_pkg::REG_IRQ_EN:  enable_d = 1'b1;
          default: ;
        endcase
      end
      mmc3o_pkg::REQ_WRITE_LO: begin
        if (in_chan.address >= mmc3o_pkg::OUTER_BASE) begin
          outer_d = in_chan.data[2:0] | data_hi[2:0];
        end
      end
      mmc3o_pkg::REQ_TICK: begin
        if (in_chan.rendering_enabled) begin
          if (count_q == 8'd0 || reload_q) begin
            count_d  = latch_q;
            reload_d = 1'b0;
          end else begin
            count_d = count_q - 8'd1;
            fire_d  = (count_q == 8'd1) && enable_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      idx_q    <= '0;
      for (int i = 0; i < 6; i++) bank_q[i] <= '0;
      mirror_q <= 1'b0;
      latch_q  <= '0;
      count_q  <= '0;
      reload_q <= 1'b0;
      enable_q <= 1'b0;
      outer_q  <= '0;
      fire_q   <= 1'b0;
      clear_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      mode_q   <= mode_d;
      idx_q    <= idx_d;
      bank_q   <= bank_d;
      mirror_q <= mirror_d;
      latch_q  <= latch_d;
      count_q  <= count_d;
      reload_q <= reload_d;
      enable_q <= enable_d;
      outer_q  <= outer_d;
      fire_q   <= fire_d;
      clear_q  <= clear_d;
    end
  end

  // 2KB pages go in the low half unless the CHR mode bit swaps the halves
  always_comb begin
    logic [3:0] lo;
    logic [3:0] hi;
    lo = mode_q ? 4'd4 : 4'd0;
    hi = mode_q ? 4'd0 : 4'd4;
    for (int i = 0; i < 8; i++) dividend[i] = '0;
    dividend[lo]        = {bank_q[0][7:1], 1'b0};
    dividend[lo + 4'd1] = {bank_q[0][7:1], 1'b1};
    dividend[lo + 4'd2] = {bank_q[1][7:1], 1'b0};
    dividend[lo + 4'd3] = {bank_q[1][7:1], 1'b1};
    dividend[hi]        = bank_q[2];
    dividend[hi + 4'd1] = bank_q[3];
    dividend[hi + 4'd2] = bank_q[4];
    dividend[hi + 4'd3] = bank_q[5];
    dividend[mmc3o_pkg::PRG_LANE] = {5'b00000, outer_q};
    prg32 = prg_cnt_q[9:2];
    if (prg32 == 8'd0) prg32 = 8'd1;
    for (int i = 0; i < 8; i++) divisor[i] = chr_cnt_q;
    divisor[mmc3o_pkg::PRG_LANE] = {4'b0000, prg32};
  end

  for (genvar g = 0; g < mmc3o_pkg::NUM_LANES; g++) begin : g_lane
    mmc3o_mod_lane u_lane (
      .clk_i      (clk_i),
      .load_i     (cmd_i.load),
      .step_i     (cmd_i.step),
      .dividend_i (dividend[g]),
      .divisor_i  (divisor[g]),
      .rem_o      (rem[g])
    );
  end

  logic [7:0] page_q [8];
  logic [2:0] prg_q;
  logic [1:0] mm_q;
  logic       ofire_q, oclear_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int i = 0; i < 8; i++) begin
        page_q[i] <= (chr_cnt_q == 12'd0) ? 8'(i) : rem[i];
      end
      prg_q    <= rem[mmc3o_pkg::PRG_LANE][2:0];
      mm_q     <= four_q ? mmc3o_pkg::MIRROR_FOUR : {1'b0, mirror_q};
      ofire_q  <= fire_q;
      oclear_q <= clear_q;
    end
  end

  assign out_chan.prg_bank    = prg_q;
  assign out_chan.chr_page0   = page_q[0];
  assign out_chan.chr_page1   = page_q[1];
  assign out_chan.chr_page2   = page_q[2];
  assign out_chan.chr_page3   = page_q[3];
  assign out_chan.chr_page4   = page_q[4];
  assign out_chan.chr_page5   = page_q[5];
  assign out_chan.chr_page6   = page_q[6];
  assign out_chan.chr_page7   = page_q[7];
  assign out_chan.mirror_mode = mm_q;
  assign out_chan.irq_fire    = ofire_q;
  assign out_chan.irq_clear   = oclear_q;

endmodule

/* hdl/mmc3o_ctrl.sv */
// Controller: item sequencing and result valid flag.
`timescale 1ns / 1ps

module mmc3o_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mmc3o_pkg::ctrl_cmd_t  cmd_o
);

  localparam int unsigned StepW = $clog2(mmc3o_pkg::CALC_STEPS);

  mmc3o_pkg::state_e state_q, state_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic              ovalid_q, ovalid_d;
  logic              out_free;

  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      mmc3o_pkg::ST_IDLE: if (in_valid_i) state_d = mmc3o_pkg::ST_LOAD;
      mmc3o_pkg::ST_LOAD: begin
        state_d = mmc3o_pkg::ST_CALC;
        cnt_d   = '0;
      end
      mmc3o_pkg::ST_CALC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepW'(mmc3o_pkg::CALC_STEPS - 1)) state_d = mmc3o_pkg::ST_HOLD;
      end
      mmc3o_pkg::ST_HOLD: if (out_free) state_d = mmc3o_pkg::ST_IDLE;
      default: state_d = mmc3o_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mmc3o_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      mmc3o_pkg::ST_LOAD: cmd_o.load = 1'b1;
      mmc3o_pkg::ST_CALC: cmd_o.step = 1'b1;
      mmc3o_pkg::ST_HOLD: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.out_load)   ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mmc3o_pkg::ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

/* sim/tb_mmc3_style_mapper_with_outer_prg_bank.sv */
// Self-checking testbench for the MMC3-style mapper with an outer 32KB PRG bank register.
`timescale 1ns / 1ps

module tb_mmc3_style_mapper_with_outer_prg_bank;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 116;
  localparam int unsigned NUM_PHASES = 8;
  localparam logic [15:0] REG_PRG_PROT = 16'hA001;

  typedef struct packed {
    mmc3o_pkg::req_e req;
    logic [15:0]     address;
    logic [7:0]      data;
    logic            rend;
  } cpu_item_t;

  typedef struct packed {
    logic [2:0]      prg;
    logic [7:0][7:0] chr;
    logic [1:0]      mirror;
    logic            fire;
    logic            clear;
  } mapping_t;

  class mapper_scoreboard;
    logic [9:0]  prg_count;
    logic [11:0] chr_count;
    logic        four_scr;
    logic        chr_swap;
    logic [2:0]  bank_idx;
    logic [7:0]  bank_r [6];
    logic        mirror_r;
    logic [7:0]  irq_period;
    logic [7:0]  irq_cnt;
    logic        irq_rearm;
    logic        irq_en;
    logic [2:0]  outer_r;
    mapping_t    pending_maps[$];
    int          mismatches;

    function new();
      prg_count = 10'd16;
      chr_count = 12'd128;
      four_scr = 1'b0;
      chr_swap = 1'b0;
      bank_idx = 3'd0;
      foreach (bank_r[i]) bank_r[i] = 8'd0;
      mirror_r = 1'b0;
      irq_period = 8'd0;
      irq_cnt = 8'd0;
      irq_rearm = 1'b0;
      irq_en = 1'b0;
      outer_r = 3'd0;
      mismatches = 0;
    endfunction

    function void set_reg(mmc3o_pkg::cfg_idx_e idx, logic [11:0] v);
      case (idx)
        mmc3o_pkg::CFG_PRG_COUNT:   prg_count = v[9:0];
        mmc3o_pkg::CFG_CHR_COUNT:   chr_count = v;
        mmc3o_pkg::CFG_FOUR_SCREEN: four_scr = v[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] chr_bank(logic [7:0] b);
      int unsigned r;
      r = int'(b) % int'(chr_count);
      return r[7:0];
    endfunction

    function void note_input(cpu_item_t it);
      mapping_t    m;
      logic [7:0]  folded;
      int unsigned prg32;
      int unsigned lo;
      int unsigned hi;
      m = '0;
      case (it.req)
        mmc3o_pkg::REQ_WRITE_HI: begin
          case (it.address & mmc3o_pkg::DECODE_MASK)
            mmc3o_pkg::REG_BANK_SEL: begin
              chr_swap = it.data[7];
              bank_idx = it.data[2:0];
            end
            mmc3o_pkg::REG_BANK_DAT: if (bank_idx < 3'd6) bank_r[bank_idx] = it.data;
            mmc3o_pkg::REG_MIRROR:   mirror_r = it.data[0];
            mmc3o_pkg::REG_IRQ_LAT:  irq_period = it.data;
            mmc3o_pkg::REG_IRQ_RLD: begin
              irq_cnt = 8'd0;
              irq_rearm = 1'b1;
            end
            mmc3o_pkg::REG_IRQ_DIS: begin
              irq_en = 1'b0;
              m.clear = 1'b1;
            end
            mmc3o_pkg::REG_IRQ_EN:   irq_en = 1'b1;
            default: ;
          endcase
        end
        mmc3o_pkg::REQ_WRITE_LO: begin
          if (it.address >= mmc3o_pkg::OUTER_BASE) begin
            folded = it.data | (it.data >> 4);
            outer_r = folded[2:0];
          end
        end
        mmc3o_pkg::REQ_TICK: begin
          if (it.rend) begin
            if (irq_cnt == 8'd0 || irq_rearm) begin
              irq_cnt = irq_period;
              irq_rearm = 1'b0;
            end else begin
              irq_cnt = irq_cnt - 8'd1;
              if (irq_cnt == 8'd0 && irq_en) m.fire = 1'b1;
            end
          end
        end
        default: ;
      endcase

      prg32 = int'(prg_count) / 4;
      if (prg32 == 0) prg32 = 1;
      m.prg = 3'(int'(outer_r) % prg32);

      if (chr_count == 12'd0) begin
        for (int k = 0; k < 8; k++) m.chr[k] = 8'(k);
      end else begin
        lo = chr_swap ? 4 : 0;
        hi = 4 - lo;
        m.chr[lo + 0] = chr_bank(bank_r[0] & 8'hFE);
        m.chr[lo + 1] = chr_bank(bank_r[0] | 8'h01);
        m.chr[lo + 2] = chr_bank(bank_r[1] & 8'hFE);
        m.chr[lo + 3] = chr_bank(bank_r[1] | 8'h01);
        m.chr[hi + 0] = chr_bank(bank_r[2]);
        m.chr[hi + 1] = chr_bank(bank_r[3]);
        m.chr[hi + 2] = chr_bank(bank_r[4]);
        m.chr[hi + 3] = chr_bank(bank_r[5]);
      end
      m.mirror = four_scr ? mmc3o_pkg::MIRROR_FOUR : {1'b0, mirror_r};
      pending_maps.push_back(m);
    endfunction

    function bit field_ok(string name, logic [7:0] e, logic [7:0] a);
      if (e === a) return 1'b1;
      if (mismatches < 10) $display("mismatch on %s: expected %0d, got %0d", name, e, a);
      return 1'b0;
    endfunction

    function void check_result(mapping_t got);
      mapping_t want;
      bit       ok;
      if (pending_maps.size() == 0) begin
        if (mismatches < 10) $display("result item with no item outstanding");
        mismatches++;
        return;
      end
      want = pending_maps.pop_front();
      ok = field_ok("prg_bank", 8'(want.prg), 8'(got.prg));
      for (int k = 0; k < 8; k++)
        ok &= field_ok($sformatf("chr_page%0d", k), want.chr[k], got.chr[k]);
      ok &= field_ok("mirror_mode", 8'(want.mirror), 8'(got.mirror));
      ok &= field_ok("irq_fire", 8'(want.fire), 8'(got.fire));
      ok &= field_ok("irq_clear", 8'(want.clear), 8'(got.clear));
      if (!ok) mismatches++;
    endfunction

    function int outstanding();
      return pending_maps.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mmc3o_in_if  in_if ();
  mmc3o_cfg_if cfg_if ();
  mmc3o_out_if out_if ();

  mmc3_style_mapper_with_outer_prg_bank u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .cfg_chan_i (cfg_if),
    .out_chan_o (out_if)
  );

  mapper_scoreboard sb;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_cycles = 0;
  int unsigned cycle_count = 0;

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: checks accepted items, stalls at random or for a long hold-off
  always @(posedge clk_i) begin : sink_side
    mapping_t got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.prg = out_if.prg_bank;
        got.chr[0] = out_if.chr_page0;
        got.chr[1] = out_if.chr_page1;
        got.chr[2] = out_if.chr_page2;
        got.chr[3] = out_if.chr_page3;
        got.chr[4] = out_if.chr_page4;
        got.chr[5] = out_if.chr_page5;
        got.chr[6] = out_if.chr_page6;
        got.chr[7] = out_if.chr_page7;
        got.mirror = out_if.mirror_mode;
        got.fire = out_if.irq_fire;
        got.clear = out_if.irq_clear;
        sb.check_result(got);
      end
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send(mmc3o_pkg::req_e r, logic [15:0] a, logic [7:0] d, logic rend);
    cpu_item_t it;
    it = '{req: r, address: a, data: d, rend: rend};
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= r;
    in_if.address <= a;
    in_if.data <= d;
    in_if.rendering_enabled <= rend;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic write_reg(mmc3o_pkg::cfg_idx_e idx, logic [11:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic set_config(logic [9:0] prg, logic [11:0] chr, logic fs);
    write_reg(mmc3o_pkg::CFG_PRG_COUNT, {2'b00, prg});
    write_reg(mmc3o_pkg::CFG_CHR_COUNT, chr);
    write_reg(mmc3o_pkg::CFG_FOUR_SCREEN, {11'd0, fs});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // random address in $8000-$FFFF that decodes to the given register
  function automatic logic [15:0] hi_addr(logic [15:0] reg_addr);
    logic [15:0] noise;
    noise = 16'($urandom);
    return reg_addr | (noise & ~mmc3o_pkg::DECODE_MASK);
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(1));
  endfunction

  task automatic run_directed();
    send(mmc3o_pkg::REQ_TICK, 16'h0000, 8'h00, 1'b0);
    send(mmc3o_pkg::REQ_NONE, 16'hFFFF, 8'hFF, 1'b1);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'h8000, 8'h80, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'h8001, 8'hFF, 1'b1);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'h9FFE, 8'h01, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'h9FFF, 8'hA5, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'h8000, 8'h46, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'h8001, 8'h77, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'h8000, 8'h07, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'h8001, 8'h00, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'hA000, 8'h01, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'hBFFE, 8'hFE, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'hA001, 8'hFF, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'h0000, 8'hFF, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'h7FFF, 8'hFF, 1'b1);
    send(mmc3o_pkg::REQ_WRITE_LO, 16'h411F, 8'hFF, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_LO, 16'h4120, 8'h70, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_LO, 16'hFFFF, 8'h0A, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'hC000, 8'h02, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'hC001, 8'h00, 1'b0);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'hE001, 8'h00, 1'b0);
    repeat (4) send(mmc3o_pkg::REQ_TICK, 16'h0000, 8'h00, 1'b1);
    send(mmc3o_pkg::REQ_WRITE_HI, 16'hE000, 8'h00, 1'b0);
  endtask

  task automatic run_random(int n);
    int sent;
    int pick;
    int ticks;
    logic [15:0] a;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        send(mmc3o_pkg::REQ_WRITE_HI, hi_addr(mmc3o_pkg::REG_BANK_SEL), 8'($urandom),
             rnd_bit());
        send(mmc3o_pkg::REQ_WRITE_HI, hi_addr(mmc3o_pkg::REG_BANK_DAT), 8'($urandom),
             rnd_bit());
        sent += 2;
      end else if (pick < 50) begin
        // well-formed IRQ setup followed by a run of scanlines
        if ($urandom_range(3) == 0)
          send(mmc3o_pkg::REQ_WRITE_HI, hi_addr(mmc3o_pkg::REG_IRQ_LAT), 8'($urandom),
               rnd_bit());
        else
          send(mmc3o_pkg::REQ_WRITE_HI, hi_addr(mmc3o_pkg::REG_IRQ_LAT),
               8'($urandom_range(6)), rnd_bit());
        if (rnd_bit())
          send(mmc3o_pkg::REQ_WRITE_HI, hi_addr(mmc3o_pkg::REG_IRQ_RLD), 8'($urandom),
               rnd_bit());
        if ($urandom_range(4) != 0)
          send(mmc3o_pkg::REQ_WRITE_HI, hi_addr(mmc3o_pkg::REG_IRQ_EN), 8'($urandom),
               rnd_bit());
        else
          send(mmc3o_pkg::REQ_WRITE_HI, hi_addr(mmc3o_pkg::REG_IRQ_DIS), 8'($urandom),
               rnd_bit());
        ticks = $urandom_range(1, 10);
        repeat (ticks)
          send(mmc3o_pkg::REQ_TICK, 16'($urandom), 8'($urandom), ($urandom_range(9) != 0));
        sent += 3 + ticks;
      end else if (pick < 58) begin
        send(mmc3o_pkg::REQ_WRITE_HI, hi_addr(mmc3o_pkg::REG_MIRROR), 8'($urandom),
             rnd_bit());
        sent++;
      end else if (pick < 68) begin
        if ($urandom_range(4) == 0) a = 16'($urandom_range(16'h4020, 16'h411F));
        else a = 16'($urandom_range(16'h4120, 16'hFFFF));
        send(mmc3o_pkg::REQ_WRITE_LO, a, 8'($urandom), rnd_bit());
        sent++;
      end else if (pick < 78) begin
        send(mmc3o_pkg::REQ_TICK, 16'($urandom), 8'($urandom), rnd_bit());
        sent++;
      end else if (pick < 84) begin
        send(mmc3o_pkg::REQ_WRITE_HI,
             hi_addr(rnd_bit() ? mmc3o_pkg::REG_IRQ_EN : mmc3o_pkg::REG_IRQ_DIS),
             8'($urandom), rnd_bit());
        sent++;
      end else if (pick < 88) begin
        send(mmc3o_pkg::REQ_WRITE_HI, hi_addr(REG_PRG_PROT), 8'($urandom), rnd_bit());
        sent++;
      end else begin
        send(mmc3o_pkg::req_e'($urandom_range(3)), 16'($urandom), 8'($urandom),
             rnd_bit());
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    in_if.valid = 1'b0;
    in_if.req_type = mmc3o_pkg::REQ_NONE;
    in_if.address = 16'd0;
    in_if.data = 8'd0;
    in_if.rendering_enabled = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = mmc3o_pkg::CFG_PRG_COUNT;
    cfg_if.data = 12'd0;
    out_if.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 59; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 59; end
        default: begin src_idle_pct = 33; sink_stall_pct = 33; end
      endcase
      case (ph)
        0: set_config(10'd16, 12'd128, 1'b0);
        1: set_config(10'd2, 12'd0, 1'b1);
        2: set_config(10'd512, 12'd2048, 1'b0);
        3: set_config(10'd3, 12'd1, 1'b1);
        5: set_config(10'd20, 12'd255, 1'b0);
        6: set_config(10'd28, 12'd6, 1'b1);
        7: set_config(10'd511, 12'd2047, 1'b0);
        default: set_config(10'($urandom_range(2, 512)), 12'($urandom_range(2048)),
                            rnd_bit());
      endcase
      if (ph == 0) run_directed();
      run_random(ITEMS_PER_PHASE / 2);
      if (ph == 0) begin
        // long receiver hold-off while items keep coming
        hold_cycles = 300;
      end
      if (ph == 1) begin
        drain();
      end
      run_random(ITEMS_PER_PHASE / 2);
      drain();
      repeat (10) @(posedge clk_i);
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/mmc3o_pkg.sv
hdl/mmc3o_if.sv
hdl/mmc3o_mod_lane.sv
hdl/mmc3o_dp.sv
hdl/mmc3o_ctrl.sv
hdl/mmc3_style_mapper_with_outer_prg_bank.sv
sim/tb_mmc3_style_mapper_with_outer_prg_bank.sv
